/* sv/pnt_pkg.sv */
package pnt_pkg;

    localparam int PNT_VALUE_BITS = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_CHECK,
        ST_OUT
    } pnt_state_t;

endpackage

/* sv/pnt_div.sv */
module pnt_div #(
    parameter int W = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     divisor_reg, divisor_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    // one quotient bit per cycle, restoring form
    always_comb
    begin
        trial        = {rem_reg, quot_reg[W-1]};
        diff         = trial - {1'b0, divisor_reg};
        fits         = trial >= {1'b0, divisor_reg};
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            rem_next     = '0;
            quot_next    = dividend;
            divisor_next = divisor;
            count_next   = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[W-1:0] : trial[W-1:0];
            quot_next  = {quot_reg[W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

/* sv/perfect_number_tester.sv */
// Perfect number tester. Each candidate on the input channel yields one result: the
// candidate echoed on tested_value and is_perfect set when the proper divisors of the
// candidate add up to it (1 is never perfect). Divisors are found by trial division with
// a bit-serial divider that produces one quotient bit per cycle. Trials run from 2 up to
// floor(sqrt(candidate)) + 1, the last one only finding that the divisor has passed the
// square root, and stop early once the divisor sum passes the candidate. One candidate is
// worked on at a time; a finished result sits in the output register while the next
// candidate is taken in.
module perfect_number_tester
    import pnt_pkg::*;
#(
    parameter int VALUE_BITS = PNT_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] candidate,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] tested_value,
    output logic                  is_perfect
);

    localparam int SUM_W = VALUE_BITS + 2;

    pnt_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic                  verdict_reg, verdict_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] tested_value_reg, tested_value_next;
    logic                  is_perfect_reg, is_perfect_next;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] quot;
    logic [VALUE_BITS-1:0] rem;
    logic [SUM_W-1:0]      cofactor;

    pnt_div #(
        .W (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        d_next            = d_reg;
        total_next        = total_reg;
        verdict_next      = verdict_reg;
        out_valid_next    = out_valid_reg;
        tested_value_next = tested_value_reg;
        is_perfect_next   = is_perfect_reg;
        div_start         = 1'b0;
        in_ready          = 1'b0;
        cofactor          = (quot != d_reg) ? SUM_W'(quot) : '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    n_next     = candidate;
                    d_next     = VALUE_BITS'(2);
                    total_next = SUM_W'(1);
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                // the sum only grows, so passing the candidate settles the answer
                if (total_reg > SUM_W'(n_reg))
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // d > n/d means d*d > n: all divisor pairs seen
                if (d_reg > quot)
                begin
                    verdict_next = (n_reg != VALUE_BITS'(1)) && (total_reg == SUM_W'(n_reg));
                    state_next   = ST_OUT;
                end
                else
                begin
                    if (rem == '0)
                        total_next = total_reg + SUM_W'(d_reg) + cofactor;
                    d_next     = d_reg + VALUE_BITS'(1);
                    state_next = ST_START;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    tested_value_next = n_reg;
                    is_perfect_next   = verdict_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg            <= n_next;
        d_reg            <= d_next;
        total_reg        <= total_next;
        verdict_reg      <= verdict_next;
        tested_value_reg <= tested_value_next;
        is_perfect_reg   <= is_perfect_next;
    end

    assign out_valid    = out_valid_reg;
    assign tested_value = tested_value_reg;
    assign is_perfect   = is_perfect_reg;

endmodule

/* tb/sv/perfect_number_tester_tb.sv */
module perfect_number_tester_tb;
    import pnt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [PNT_VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t value;
        logic   perfect;
    } verdict_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    value_t candidate;
    logic   out_valid;
    logic   out_ready;
    value_t tested_value;
    logic   is_perfect;

    verdict_t pending_verdicts[$];
    verdict_t head_verdict;
    int       mismatch_count = 0;

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    int hold_request = 0;
    int hold_left    = 0;
    int stall_left   = 0;

    perfect_number_tester #(
        .VALUE_BITS(PNT_VALUE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tested_value(tested_value),
        .is_perfect  (is_perfect)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // proper divisor sum by trial division, stopping once it passes the value
    function automatic logic predict_perfect(input value_t value);
        longint unsigned n     = 64'(value);
        longint unsigned total = 64'(1);
        longint unsigned d;
        longint unsigned co;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
            begin
                co = n / d;
                total += (co != d) ? d + co : d;
                if (total > n)
                    return 1'b0;
            end
        end
        return (n != 1) && (total == n);
    endfunction

    task automatic send_candidate(input value_t value);
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_verdicts.push_back('{value: value, perfect: predict_perfect(value)});
    endtask

    task automatic close_test();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly small values; wide values come as multiples of 6 or odd multiples of 945,
    // both abundant, so the divisor sum passes the value after few trials
    function automatic value_t pick_candidate();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return value_t'($urandom_range(0, 3000));
        else if (sel < 75)
            return value_t'(6 * $urandom_range(1, 357913941));
        else if (sel < 92)
            return value_t'(945 * (2 * $urandom_range(0, 1136234) + 1));
        else
        begin
            case ($urandom_range(0, 3))
                0:       return value_t'(6);
                1:       return value_t'(28);
                2:       return value_t'(496);
                default: return value_t'(8128);
            endcase
        end
    endfunction

    task automatic test_boundary_values();
        send_candidate(value_t'(0));
        send_candidate(value_t'(1));
        send_candidate(value_t'(2));
        send_candidate(value_t'(3));
        // perfect squares count the root once
        send_candidate(value_t'(4));
        send_candidate(value_t'(9));
        send_candidate(value_t'(25));
        send_candidate(value_t'(945));
        send_candidate(31'd2147483646);
        // prime at the top of the range, longest full walk
        send_candidate(31'd2147483647);
        close_test();
    endtask

    task automatic test_perfect_numbers();
        send_candidate(value_t'(6));
        send_candidate(value_t'(28));
        send_candidate(value_t'(496));
        send_candidate(value_t'(8128));
        send_candidate(value_t'(33550336));
        close_test();
    endtask

    task automatic test_successive_walk();
        for (int v = 10; v < 20; v++)
            send_candidate(value_t'(v));
        close_test();
    endtask

    task automatic test_output_backpressure();
        hold_request = 2000;
        for (int i = 0; i < 6; i++)
            send_candidate(value_t'($urandom_range(2, 100)));
        close_test();
    endtask

    task automatic test_random_with_idling();
        for (int i = 0; i < 50; i++)
            send_candidate(pick_candidate());
        close_test();
    endtask

    task automatic test_random_streaming();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        for (int i = 0; i < 20; i++)
            send_candidate(pick_candidate());
        close_test();
    endtask

    // result side: long hold-offs on request, otherwise short random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (out_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got tested_value %0d",
                         $time, tested_value);
                mismatch_count++;
            end
            else
            begin
                head_verdict = pending_verdicts.pop_front();
                if (tested_value !== head_verdict.value)
                begin
                    $display("%0t: tested_value mismatch, expected %0d, got %0d",
                             $time, head_verdict.value, tested_value);
                    mismatch_count++;
                end
                if (is_perfect !== head_verdict.perfect)
                begin
                    $display("%0t: is_perfect mismatch for %0d, expected %0b, got %0b",
                             $time, head_verdict.value, head_verdict.perfect, is_perfect);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        candidate = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_boundary_values();
        test_perfect_numbers();
        test_successive_walk();
        test_output_backpressure();
        test_random_with_idling();
        test_random_streaming();

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
